// ===== rtl/tdpf_pkg.sv =====
`timescale 1ns / 1ps

package tdpf_pkg;

	// Report counter value after reset, also the first divisor tried
	localparam int unsigned FIRST_COUNT = 2;

endpackage

// ===== rtl/tdpf_in_if.sv =====
`timescale 1ns / 1ps

interface tdpf_in_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

// ===== rtl/tdpf_out_if.sv =====
`timescale 1ns / 1ps

interface tdpf_out_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] tested_value;
	logic                  is_prime;
	logic                  reported;
	logic                  limit_reached;

	modport source (output valid, output tested_value, output is_prime,
		output reported, output limit_reached, input ready);
	modport sink   (input valid, input tested_value, input is_prime,
		input reported, input limit_reached, output ready);
endinterface

// ===== rtl/tdpf_rem.sv =====
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module tdpf_rem #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [VALUE_BITS-1:0] rem
);
	localparam int IDX_BITS = $clog2(VALUE_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [VALUE_BITS-1:0] dsr_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   diff;
	logic                  fits;

	assign shifted = {rem_q, dvd_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= IDX_BITS'(VALUE_BITS - 1);
			end else if (busy_q) begin
				idx_q <= idx_q - 1'b1;
				if (idx_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			rem_q <= fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/trial_division_prime_filter.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload
// in_ch    in   candidate
// out_ch   out  tested_value, is_prime, reported, limit_reached
//
// One candidate at a time. Each divisor d (2, 3, ... while d*d <= candidate)
// is tried in turn in the shared remainder unit. Reset clears the report
// counter to two and limit_q to zero. A result waits in the output
// register while the next request is accepted; a stalled output holds the
// sequencer before its result is loaded.
module trial_division_prime_filter #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [VALUE_BITS-1:0] cfg_wdata,
	tdpf_in_if.sink               in_ch,
	tdpf_out_if.source            out_ch
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] limit_q;
	logic [VALUE_BITS:0]   cnt_q;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [VALUE_BITS+1:0] sq_q;
	logic                  prime_q;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_prime_q;
	logic                  out_rep_q;
	logic                  out_lim_q;

	logic                  rem_start;
	logic                  rem_busy;
	logic                  rem_done;
	logic [VALUE_BITS-1:0] rem_val;

	logic                  too_small;
	logic                  past_root;
	logic                  in_window;
	logic                  rep;
	logic [VALUE_BITS:0]   cnt_next;
	logic                  out_free;

	assign too_small = cand_q < VALUE_BITS'(tdpf_pkg::FIRST_COUNT);
	assign past_root = sq_q > {2'b00, cand_q};
	assign rem_start = (state_q == ST_CHECK) && !too_small && !past_root;
	assign in_window = cnt_q <= {1'b0, limit_q};
	assign rep       = prime_q && in_window;
	assign cnt_next  = cnt_q + {{VALUE_BITS{1'b0}}, rep};
	assign out_free  = !out_valid_q || out_ch.ready;

	tdpf_rem #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(cand_q),
		.divisor (div_q),
		.busy    (rem_busy),
		.done    (rem_done),
		.rem     (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= '0;
			cnt_q       <= (VALUE_BITS+1)'(tdpf_pkg::FIRST_COUNT);
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_prime_q <= 1'b0;
			out_rep_q   <= 1'b0;
			out_lim_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (too_small || past_root) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (rem_done) begin
						state_q <= (rem_val == '0) ? ST_EMIT : ST_CHECK;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						out_value_q <= cand_q;
						out_prime_q <= prime_q;
						out_rep_q   <= rep;
						out_lim_q   <= cnt_next > {1'b0, limit_q};
						cnt_q       <= cnt_next;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			cand_q <= in_ch.candidate;
			div_q  <= VALUE_BITS'(tdpf_pkg::FIRST_COUNT);
			sq_q   <= (VALUE_BITS+2)'(tdpf_pkg::FIRST_COUNT * tdpf_pkg::FIRST_COUNT);
		end
		if (state_q == ST_CHECK) begin
			prime_q <= !too_small;
		end
		if (state_q == ST_DIVIDE && rem_done) begin
			if (rem_val == '0) begin
				prime_q <= 1'b0;
			end else begin
				// advance to the next divisor: (d+1)^2 = d^2 + 2d + 1
				sq_q  <= sq_q + {1'b0, div_q, 1'b1};
				div_q <= div_q + 1'b1;
			end
		end
	end

	assign in_ch.ready          = (state_q == ST_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.tested_value  = out_value_q;
	assign out_ch.is_prime      = out_prime_q;
	assign out_ch.reported      = out_rep_q;
	assign out_ch.limit_reached = out_lim_q;

`ifndef SYNTH
	a_cnt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= (VALUE_BITS+1)'(tdpf_pkg::FIRST_COUNT))
		else $error("report counter below its start value");

	a_rep_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_rep_q || out_prime_q))
		else $error("report flagged for a composite");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> !rem_busy)
		else $error("remainder unit started while busy");

	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (!rem_busy && !rem_done))
		else $error("input ready while a division is in flight");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_EMIT))
		else $error("report counter changed outside result load");
`endif
endmodule
